// ===== src/keyframe_camera_interpolator_macros.svh =====
// assertion macros for the keyframe camera interpolator
`ifndef KEYFRAME_CAMERA_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_CAMERA_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define KCI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define KCI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/kci_pkg.sv =====
package kci_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = KEY_W + 1;
    localparam int NCOORD   = 6;
    localparam int FRAC_W   = 16;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_START  = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ENDED       = 3'd1,
        ST_NOT_STARTED = 3'd2,
        ST_ACCEPTED    = 3'd3,
        ST_FULL        = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DIV,
        S_MUL,
        S_BLEND,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [31:0]                    stamp;
        logic [NCOORD-1:0][31:0]        coord;
    } key_t;

endpackage

// ===== src/keyframe_camera_interpolator.sv =====
// keyframe camera interpolator
// input channel: in_valid/in_ready carrying cmd, stamp and one keyframe word
// output channel: out_valid/out_ready carrying status and the blended camera
// every input word yields exactly one output word
// append, clear and start finish with a registered result: it is shown on the
// cycle after acceptance, so they can be taken one per cycle while out_ready holds
// a query rotates the keyframe cell chain once, one cell per cycle, for the
// bracket search, then evaluates; with a bracket it runs the serial divider
// (16 quotient bits, then the done flag), multiplies, adds into the result
// register and raises out_valid once the output register is free; without
// one it reports ended or not started; the next word is taken back in idle
// one word is in flight at a time; a new word is taken once the output
// register is empty or being emptied
// while the receiver stalls the result stays held and no input is taken
// reset empties the table, clears playing and drops any pending result
module keyframe_camera_interpolator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [31:0]        stamp,
    input  logic signed [31:0] in_eye_x,
    input  logic signed [31:0] in_eye_y,
    input  logic signed [31:0] in_eye_z,
    input  logic signed [31:0] in_look_x,
    input  logic signed [31:0] in_look_y,
    input  logic signed [31:0] in_look_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] out_eye_x,
    output logic signed [31:0] out_eye_y,
    output logic signed [31:0] out_eye_z,
    output logic signed [31:0] out_look_x,
    output logic signed [31:0] out_look_y,
    output logic signed [31:0] out_look_z
);
    import kci_pkg::*;

`include "keyframe_camera_interpolator_macros.svh"

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               playing_reg, playing_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [NCOORD-1:0][31:0] res_reg, res_next;
    logic [31:0]        stamp_reg, stamp_next;
    key_t               lo_reg, lo_next;
    key_t               hi_reg, hi_next;
    logic               have_lo_reg, have_lo_next;
    logic               have_hi_reg, have_hi_next;
    logic signed [49:0] prod_reg [NCOORD];
    logic signed [49:0] prod_next [NCOORD];

    key_t               cell_key [MAX_KEYS];
    key_t               wr_key;
    logic               in_fire;
    logic               out_free;
    logic               scan_en;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  frac;
    logic [31:0]        div_num;
    logic [31:0]        div_den;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign scan_en  = (state_reg == S_SCAN);

    assign wr_key.stamp    = stamp;
    assign wr_key.coord[0] = in_eye_x;
    assign wr_key.coord[1] = in_eye_y;
    assign wr_key.coord[2] = in_eye_z;
    assign wr_key.coord[3] = in_look_x;
    assign wr_key.coord[4] = in_look_y;
    assign wr_key.coord[5] = in_look_z;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEYS; gi++)
        begin : g_cell
            kci_cell u_cell (
                .clk      (clk),
                .shift_en (scan_en),
                .wr_en    (in_fire && (cmd == CMD_APPEND) && (count_reg == CNT_W'(gi))),
                .wr_key   (wr_key),
                .next_key (cell_key[(gi + 1) % MAX_KEYS]),
                .key      (cell_key[gi])
            );
        end
    endgenerate

    assign div_num = stamp_reg - lo_reg.stamp;
    assign div_den = hi_reg.stamp - lo_reg.stamp;

    kci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (frac)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        playing_next   = playing_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        res_next       = res_reg;
        stamp_next     = stamp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        have_lo_next   = have_lo_reg;
        have_hi_next   = have_hi_reg;
        div_start      = 1'b0;
        for (int k = 0; k < NCOORD; k++)
        begin
            prod_next[k] = prod_reg[k];
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_next = '0;
                    unique case (cmd)
                        CMD_APPEND:
                        begin
                            if (count_reg >= CNT_W'(MAX_KEYS))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next  = count_reg + CNT_W'(1);
                                status_next = ST_ACCEPTED;
                            end
                            out_valid_next = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            count_next     = '0;
                            status_next    = ST_ACCEPTED;
                            out_valid_next = 1'b1;
                        end
                        CMD_START:
                        begin
                            playing_next   = 1'b1;
                            status_next    = ST_ACCEPTED;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            stamp_next   = stamp;
                            scan_next    = '0;
                            have_lo_next = 1'b0;
                            have_hi_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // cell 0 holds entry scan_reg while the chain rotates
                if (scan_reg < count_reg)
                begin
                    if (cell_key[0].stamp <= stamp_reg)
                    begin
                        lo_next      = cell_key[0];
                        have_lo_next = 1'b1;
                    end
                    else if (!have_hi_reg)
                    begin
                        hi_next      = cell_key[0];
                        have_hi_next = 1'b1;
                    end
                end
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(MAX_KEYS - 1))
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (have_lo_reg && have_hi_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    res_next = '0;
                    if (playing_reg)
                    begin
                        playing_next = 1'b0;
                        status_next  = ST_ENDED;
                    end
                    else
                    begin
                        status_next = ST_NOT_STARTED;
                    end
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                for (int k = 0; k < NCOORD; k++)
                begin
                    prod_next[k] = (33'(signed'(hi_reg.coord[k]))
                                   - 33'(signed'(lo_reg.coord[k])))
                                   * $signed({1'b0, frac});
                end
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                for (int k = 0; k < NCOORD; k++)
                begin
                    res_next[k] = lo_reg.coord[k] + prod_reg[k][47:16];
                end
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            playing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            have_lo_reg   <= 1'b0;
            have_hi_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            playing_reg   <= playing_next;
            out_valid_reg <= out_valid_next;
            have_lo_reg   <= have_lo_next;
            have_hi_reg   <= have_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        res_reg    <= res_next;
        stamp_reg  <= stamp_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        for (int k = 0; k < NCOORD; k++)
        begin
            prod_reg[k] <= prod_next[k];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_eye_x  = res_reg[0];
    assign out_eye_y  = res_reg[1];
    assign out_eye_z  = res_reg[2];
    assign out_look_x = res_reg[3];
    assign out_look_y = res_reg[4];
    assign out_look_z = res_reg[5];

    `KCI_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_KEYS))
    `KCI_ASSERT_NXT(a_query_scans, in_fire && (cmd == CMD_QUERY), state_reg == S_SCAN)
    `KCI_ASSERT_IMP(a_div_in_state, div_done, state_reg == S_DIV)
    `KCI_ASSERT_IMP(a_ok_bracketed, (state_reg == S_BLEND), have_lo_reg && have_hi_reg)

endmodule

// ===== src/kci_cell.sv =====
module kci_cell (
    input  logic        clk,
    input  logic        shift_en,
    input  logic        wr_en,
    input  kci_pkg::key_t wr_key,
    input  kci_pkg::key_t next_key,
    output kci_pkg::key_t key
);
    import kci_pkg::*;

    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            key_next = wr_key;
        end
        else if (shift_en)
        begin
            key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

// ===== src/kci_div.sv =====
module kci_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                num,
    input  logic [31:0]                den,
    output logic                       done,
    output logic [kci_pkg::FRAC_W-1:0] quo
);
    import kci_pkg::*;

    logic [31:0]       rem_reg, rem_next;
    logic [31:0]       den_reg, den_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [32:0]       trial;

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, 1'b0};
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, remainder stays below divisor
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kci_pkg::*;

    typedef struct {
        status_t     st;
        logic [31:0] pos [NCOORD];
    } camera_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         cmd = CMD_CLEAR;
    logic [31:0]        stamp = '0;
    logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
    logic signed [31:0] in_look_x = '0, in_look_y = '0, in_look_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] out_eye_x, out_eye_y, out_eye_z;
    logic signed [31:0] out_look_x, out_look_y, out_look_z;

    keyframe_camera_interpolator dut (.*);

    always #5 clk = ~clk;

    // mirror of the keyframe table
    logic [31:0] key_stamp [MAX_KEYS];
    logic [31:0] key_pos [MAX_KEYS][NCOORD];
    int          key_total;
    bit          is_playing;

    camera_t     pending_views [$];
    int          words_sent, words_checked, errors, queries_ok, ended_cnt, full_cnt;
    bit          quiet, hold_req;
    int          idle_cycles;
    string       coord_name [NCOORD] = '{"out_eye_x", "out_eye_y", "out_eye_z",
                                          "out_look_x", "out_look_y", "out_look_z"};

    function automatic logic [31:0] lerp_coord(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] f);
        longint sum;
        sum = longint'($signed(a)) * longint'(65536 - f) + longint'($signed(b)) * longint'(f);
        return 32'(sum >>> 16);
    endfunction

    function automatic camera_t predict_view(cmd_t c, logic [31:0] t,
                                             logic [31:0] p [NCOORD]);
        camera_t r;
        bit has_lo, has_hi;
        int lo, hi;
        logic [31:0] span, ofs, frac;
        r.st = ST_ACCEPTED;
        for (int j = 0; j < NCOORD; j++) r.pos[j] = '0;
        has_lo = 0; has_hi = 0; lo = 0; hi = 0;
        case (c)
            CMD_APPEND:
            begin
                if (key_total >= MAX_KEYS) r.st = ST_FULL;
                else
                begin
                    key_stamp[key_total] = t;
                    key_pos[key_total] = p;
                    key_total++;
                end
            end
            CMD_CLEAR: key_total = 0;
            CMD_START: is_playing = 1;
            default:
            begin
                for (int i = 0; i < key_total; i++)
                begin
                    if (key_stamp[i] <= t)
                    begin
                        lo = i;
                        has_lo = 1;
                    end
                    else if (!has_hi)
                    begin
                        hi = i;
                        has_hi = 1;
                    end
                end
                if (!has_lo || !has_hi)
                begin
                    r.st = is_playing ? ST_ENDED : ST_NOT_STARTED;
                    is_playing = 0;
                end
                else
                begin
                    span = key_stamp[hi] - key_stamp[lo];
                    ofs = t - key_stamp[lo];
                    frac = 32'(({32'd0, ofs} << 16) / {32'd0, span});
                    r.st = ST_OK;
                    for (int j = 0; j < NCOORD; j++)
                        r.pos[j] = lerp_coord(key_pos[lo][j], key_pos[hi][j], frac);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_word(cmd_t c, logic [31:0] t, logic [31:0] p [NCOORD]);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        cmd = c;
        stamp = t;
        {in_eye_x, in_eye_y, in_eye_z} = {p[0], p[1], p[2]};
        {in_look_x, in_look_y, in_look_z} = {p[3], p[4], p[5]};
        do @(posedge clk); while (!in_ready);
        pending_views.insert(pending_views.size(), predict_view(c, t, p));
        words_sent++;
    endtask

    task automatic send_simple(cmd_t c, logic [31:0] t);
        logic [31:0] p [NCOORD];
        foreach (p[j]) p[j] = $urandom;
        send_word(c, t, p);
    endtask

    task automatic send_key(logic [31:0] t);
        send_simple(CMD_APPEND, t);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_simple(CMD_QUERY, 32'd0);
        send_simple(CMD_START, $urandom);
        send_simple(CMD_QUERY, 32'hFFFF_FFFF);
        send_simple(CMD_QUERY, 32'd5);
    endtask

    task automatic test_extremes();
        logic [31:0] lo_p [NCOORD], hi_p [NCOORD];
        foreach (lo_p[j])
        begin
            lo_p[j] = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            hi_p[j] = (j % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        send_simple(CMD_CLEAR, 32'd0);
        send_word(CMD_APPEND, 32'd0, lo_p);
        send_word(CMD_APPEND, 32'hFFFF_FFFF, hi_p);
        send_simple(CMD_START, 32'd0);
        send_simple(CMD_QUERY, 32'd0);
        send_simple(CMD_QUERY, 32'h8000_0000);
        send_simple(CMD_QUERY, 32'hFFFF_FFFE);
        send_simple(CMD_QUERY, 32'hFFFF_FFFF);
        send_simple(CMD_QUERY, 32'd1);
        // unsorted table: later key earlier in time
        send_key(32'd500);
        send_key(32'd100);
        send_simple(CMD_QUERY, 32'd300);
    endtask

    task automatic test_full_table();
        send_simple(CMD_CLEAR, 32'd0);
        for (int i = 0; i < MAX_KEYS + 2; i++) send_key(i * 1000);
        send_simple(CMD_QUERY, 32'd63500);
        send_simple(CMD_QUERY, 32'd62999);
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 6; i++) send_simple(CMD_QUERY, $urandom);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_simple(CMD_START, 32'd0);
    endtask

    task automatic random_track();
        int n;
        logic [31:0] tt [$];
        logic [31:0] q;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) tt.insert(tt.size(), $urandom);
        if ($urandom_range(0, 4) != 0) tt.sort();
        send_simple(CMD_CLEAR, $urandom);
        foreach (tt[i]) send_key(tt[i]);
        if ($urandom_range(0, 5) != 0) send_simple(CMD_START, $urandom);
        repeat ($urandom_range(1, 6))
        begin
            int k;
            k = $urandom_range(0, tt.size() - 1);
            if ($urandom_range(0, 5) == 0 || k + 1 >= tt.size() || tt[k + 1] <= tt[k])
                q = $urandom;
            else
                q = tt[k] + 32'({32'd0, $urandom} % {32'd0, tt[k + 1] - tt[k]});
            send_simple(CMD_QUERY, q);
        end
        if ($urandom_range(0, 6) == 0) send_simple(cmd_t'($urandom_range(0, 3)), $urandom);
    endtask

    task automatic test_random(int target);
        while (words_sent < target) random_track();
    endtask

    // receiver side
    int hold_left, stall_left;
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req <= 0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    always @(posedge clk)
    begin
        camera_t e;
        logic [31:0] got [NCOORD];
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_eye_x, out_eye_y, out_eye_z, out_look_x, out_look_y, out_look_z};
            if (pending_views.size() == 0)
            begin
                $error("unexpected word status=%0d", status);
                errors++;
            end
            else
            begin
                e = pending_views.pop_front();
                words_checked++;
                if (e.st == ST_OK) queries_ok++;
                if (e.st == ST_ENDED) ended_cnt++;
                if (e.st == ST_FULL) full_cnt++;
                if (status !== e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    errors++;
                end
                for (int j = 0; j < NCOORD; j++)
                    if (got[j] !== e.pos[j])
                    begin
                        $error("%s expected %h actual %h", coord_name[j], e.pos[j], got[j]);
                        errors++;
                    end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= 5000)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_table();
        test_extremes();
        test_full_table();
        test_backpressure();
        test_drain_pause();
        test_random(700);
        quiet = 1;
        test_random(750);
        @(negedge clk);
        in_valid = 1'b0;
        wait_drained();
        repeat (150) @(posedge clk);
        $display("tb: %0d words sent, %0d checked: %0d blended frames, %0d ended, %0d full",
                 words_sent, words_checked, queries_ok, ended_cnt, full_cnt);
        $display("tb: covered empty, extreme, unsorted and full tables under stalls");
        if (errors == 0 && pending_views.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
